[design/tmrm_pkg.sv]
// Package for the tiered mask rule matcher.
// Holds the rule entry layout, the sequencer states and shared constants.
// Depends on nothing.
package tmrm_pkg;

    localparam int DEF_MAX_RULES = 64;
    localparam int FIELD_W       = 64;
    localparam int TIER_W        = 8;
    localparam int INDEX_W       = 6;
    localparam int COUNT_W       = 7;
    localparam int ASSIGN_W      = 2;

    localparam logic [TIER_W-1:0]   TOP_ASSIGNING_TIER = 8'd2;
    localparam logic [ASSIGN_W-1:0] NO_TIER            = 2'd0;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_EVAL  = 1'b1;

    typedef struct packed {
        logic [TIER_W-1:0]  tier;
        logic [FIELD_W-1:0] required;
        logic [FIELD_W-1:0] forbidden;
        logic [FIELD_W-1:0] result;
    } t_rule;

    localparam int RULE_W = $bits(t_rule);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DONE
    } t_state;

endpackage

[design/tmrm_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
// Width and depth are parameters. Depends on nothing.
module tmrm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                     i_wr_data,
    input  logic                                 i_rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                     o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[design/tiered_mask_rule_matcher.sv]
// An evaluate transaction reads up to the walk length (capped at MAX_RULES) rule entries,
// one per cycle, and stops at the first rule above an assigned tier; from the done state its
// result is loaded into the output register once that register is free, and the sequencer
// then returns to idle for the next input. The input stalls while an evaluation is in
// progress or its result waits for the output register. Synchronous active-low reset clears
// the sequencer, the output valid and the walk length; rule storage is not cleared.
module tiered_mask_rule_matcher
    import tmrm_pkg::*;
#(
    parameter int MAX_RULES = DEF_MAX_RULES
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_mode,
    input  logic [INDEX_W-1:0] i_rule_index,
    input  logic [TIER_W-1:0]  i_rule_tier,
    input  logic [FIELD_W-1:0] i_rule_required,
    input  logic [FIELD_W-1:0] i_rule_forbidden,
    input  logic [FIELD_W-1:0] i_rule_result,
    input  logic [FIELD_W-1:0] i_fact_bits,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [FIELD_W-1:0] o_match_mask,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [COUNT_W-1:0] i_cfg_data
);

    localparam int AW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
    localparam int CW = $clog2(MAX_RULES + 1);

    t_state              r_state, n_state;
    logic [COUNT_W-1:0]  r_walk_len;
    logic [AW-1:0]       r_idx, n_idx;
    logic [CW-1:0]       r_limit, n_limit;
    logic [FIELD_W-1:0]  r_facts, n_facts;
    logic [FIELD_W-1:0]  r_mask, n_mask;
    logic [ASSIGN_W-1:0] r_assigned, n_assigned;
    logic                r_out_valid, n_out_valid;
    logic [FIELD_W-1:0]  r_out_mask, n_out_mask;

    logic                in_acc;
    logic                out_free;
    logic [CW-1:0]       limit;
    logic                wr_en;
    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    logic [RULE_W-1:0]   rd_data;
    t_rule               rule;
    t_rule               wr_rule;
    logic                hit;
    logic                cut;
    logic                last;

    assign o_cfg_ready = i_rst_n;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign limit       = (32'(r_walk_len) > MAX_RULES) ? CW'(MAX_RULES) : CW'(r_walk_len);

    assign rule = t_rule'(rd_data);
    assign hit  = ((r_facts & rule.required) == rule.required)
               && ((r_facts & rule.forbidden) == '0);
    assign cut  = (r_assigned != NO_TIER)
               && (rule.tier > {{(TIER_W-ASSIGN_W){1'b0}}, r_assigned});
    assign last = (CW'(r_idx) + CW'(1)) == r_limit;

    assign wr_rule.tier      = i_rule_tier;
    assign wr_rule.required  = i_rule_required;
    assign wr_rule.forbidden = i_rule_forbidden;
    assign wr_rule.result    = i_rule_result;

    tmrm_ram #(
        .WIDTH (RULE_W),
        .DEPTH (MAX_RULES)
    ) u_rules (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (AW'(i_rule_index)),
        .i_wr_data (wr_rule),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && i_mode == MODE_EVAL) begin
                    n_state = (limit == '0) ? ST_DONE : ST_WALK;
                end
            end
            ST_WALK: begin
                if (cut || last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall  = 1'b1;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = '0;
        n_idx       = r_idx;
        n_limit     = r_limit;
        n_facts     = r_facts;
        n_mask      = r_mask;
        n_assigned  = r_assigned;
        n_out_mask  = r_out_mask;
        n_out_valid = r_out_valid && i_out_stall;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = !i_rst_n;
                if (in_acc && i_mode == MODE_WRITE) begin
                    wr_en = 32'(i_rule_index) < MAX_RULES;
                end
                if (in_acc && i_mode == MODE_EVAL) begin
                    rd_en      = 1'b1;
                    n_idx      = '0;
                    n_limit    = limit;
                    n_facts    = i_fact_bits;
                    n_mask     = '0;
                    n_assigned = NO_TIER;
                end
            end
            ST_WALK: begin
                rd_en   = 1'b1;
                rd_addr = r_idx + AW'(1);
                n_idx   = r_idx + AW'(1);
                if (!cut && hit) begin
                    n_mask = r_mask | rule.result;
                    if (r_assigned == NO_TIER && rule.tier != '0
                            && rule.tier <= TOP_ASSIGNING_TIER) begin
                        n_assigned = rule.tier[ASSIGN_W-1:0];
                    end
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_mask  = r_mask;
                end
            end
            default: o_in_stall = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_walk_len  <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_walk_len <= i_cfg_data;
            end
        end
        r_idx      <= n_idx;
        r_limit    <= n_limit;
        r_facts    <= n_facts;
        r_mask     <= n_mask;
        r_assigned <= n_assigned;
        r_out_mask <= n_out_mask;
    end

    assign o_out_valid  = r_out_valid;
    assign o_match_mask = r_out_mask;

    a_walk_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_WALK |-> CW'(r_idx) < r_limit)
        else $error("walk index beyond rule limit");

    a_assigned_tier: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_WALK |-> {{(TIER_W-ASSIGN_W){1'b0}}, r_assigned} <= TOP_ASSIGNING_TIER)
        else $error("assigned tier out of range");

    a_empty_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_mode == MODE_EVAL && limit == '0 |=> r_state == ST_DONE && r_mask == '0)
        else $error("empty rule table did not finish at once");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_DONE))
        else $error("result appeared without a finished walk");

endmodule

[bench/tb_top.sv]
// Self-checking testbench for tiered_mask_rule_matcher: directed and random rule writes
// and fact evaluations, with random stalls and gaps on both sides.
// Depends on tmrm_pkg and the tiered_mask_rule_matcher RTL.
module tb_top;
    import tmrm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    class rule_scoreboard;
        logic [TIER_W-1:0]  tiers[DEF_MAX_RULES];
        logic [FIELD_W-1:0] required[DEF_MAX_RULES];
        logic [FIELD_W-1:0] forbidden[DEF_MAX_RULES];
        logic [FIELD_W-1:0] results[DEF_MAX_RULES];
        bit                 written[DEF_MAX_RULES];
        logic [COUNT_W-1:0] walk_count;
        logic [FIELD_W-1:0] mask_queue[$];
        int                 errors;

        function new();
            walk_count = '0;
            errors = 0;
            foreach (written[i]) written[i] = 1'b0;
        endfunction

        function void set_count(logic [COUNT_W-1:0] value);
            walk_count = value;
        endfunction

        function int written_prefix();
            int n;
            n = 0;
            while (n < DEF_MAX_RULES && written[n]) n++;
            return n;
        endfunction

        function int pending();
            return mask_queue.size();
        endfunction

        function void note_item(logic mode, logic [INDEX_W-1:0] idx, logic [TIER_W-1:0] tier,
                                logic [FIELD_W-1:0] req, logic [FIELD_W-1:0] forb,
                                logic [FIELD_W-1:0] res, logic [FIELD_W-1:0] facts);
            logic [FIELD_W-1:0] mask;
            logic [TIER_W-1:0]  assigned;
            int                 limit;
            if (mode == MODE_WRITE) begin
                tiers[idx] = tier;
                required[idx] = req;
                forbidden[idx] = forb;
                results[idx] = res;
                written[idx] = 1'b1;
                return;
            end
            mask = '0;
            assigned = '0;
            limit = (walk_count > DEF_MAX_RULES) ? DEF_MAX_RULES : int'(walk_count);
            for (int i = 0; i < limit; i++) begin
                if (assigned != 0 && tiers[i] > assigned) break;
                if ((facts & required[i]) == required[i] && (facts & forbidden[i]) == '0) begin
                    mask |= results[i];
                    if (assigned == 0 && tiers[i] <= TOP_ASSIGNING_TIER) assigned = tiers[i];
                end
            end
            mask_queue.push_back(mask);
        endfunction

        function void check_mask(logic [FIELD_W-1:0] got);
            logic [FIELD_W-1:0] want;
            if (mask_queue.size() == 0) begin
                $error("match_mask: expected none, got %h", got);
                errors++;
                return;
            end
            want = mask_queue.pop_front();
            if (got !== want) begin
                $error("match_mask: expected %h, got %h", want, got);
                errors++;
            end
        endfunction
    endclass

    localparam logic [FIELD_W-1:0] ALL_ONES = {FIELD_W{1'b1}};
    localparam int SETTLE_CYCLES = DEF_MAX_RULES + 16;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic               i_mode = MODE_WRITE;
    logic [INDEX_W-1:0] i_rule_index = '0;
    logic [TIER_W-1:0]  i_rule_tier = '0;
    logic [FIELD_W-1:0] i_rule_required = '0;
    logic [FIELD_W-1:0] i_rule_forbidden = '0;
    logic [FIELD_W-1:0] i_rule_result = '0;
    logic [FIELD_W-1:0] i_fact_bits = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [FIELD_W-1:0] o_match_mask;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [COUNT_W-1:0] i_cfg_data = '0;

    rule_scoreboard sb = new();
    bit             quiet = 1'b0;
    int             sent = 0;

    tiered_mask_rule_matcher u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_mode           (i_mode),
        .i_rule_index     (i_rule_index),
        .i_rule_tier      (i_rule_tier),
        .i_rule_required  (i_rule_required),
        .i_rule_forbidden (i_rule_forbidden),
        .i_rule_result    (i_rule_result),
        .i_fact_bits      (i_fact_bits),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_match_mask     (o_match_mask),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_mask(o_match_mask);
    end

    initial begin
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            repeat (($urandom_range(0, 3) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 20))
            begin
                @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
            if (!quiet) begin
                repeat ($urandom_range(1, 13)) begin
                    @(posedge i_clk);
                    i_out_stall <= 1'b1;
                end
            end
        end
    end

    function automatic logic [FIELD_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [FIELD_W-1:0] pick_mask();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return ALL_ONES;
            2: return rand64();
            3: return rand64() & rand64() & rand64();
            4: return 64'd1 << $urandom_range(0, FIELD_W - 1);
            default: return rand64() & rand64() & rand64() & rand64();
        endcase
    endfunction

    function automatic logic [TIER_W-1:0] pick_tier();
        if ($urandom_range(0, 9) == 0) return TIER_W'($urandom_range(0, 255));
        return TIER_W'($urandom_range(0, 4));
    endfunction

    task automatic send_item(input logic mode, input logic [INDEX_W-1:0] idx,
                             input logic [TIER_W-1:0] tier, input logic [FIELD_W-1:0] req,
                             input logic [FIELD_W-1:0] forb, input logic [FIELD_W-1:0] res,
                             input logic [FIELD_W-1:0] facts);
        int gap;
        i_in_valid <= 1'b1;
        i_mode <= mode;
        i_rule_index <= idx;
        i_rule_tier <= tier;
        i_rule_required <= req;
        i_rule_forbidden <= forb;
        i_rule_result <= res;
        i_fact_bits <= facts;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_item(mode, idx, tier, req, forb, res, facts);
        sent++;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 13);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic write_rule(input logic [INDEX_W-1:0] idx, input logic [TIER_W-1:0] tier,
                              input logic [FIELD_W-1:0] req, input logic [FIELD_W-1:0] forb,
                              input logic [FIELD_W-1:0] res);
        send_item(MODE_WRITE, idx, tier, req, forb, res, rand64());
    endtask

    task automatic evaluate(input logic [FIELD_W-1:0] facts);
        send_item(MODE_EVAL, INDEX_W'($urandom), TIER_W'($urandom), rand64(), rand64(),
                  rand64(), facts);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_walk_len(input logic [COUNT_W-1:0] value);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.set_count(value);
    endtask

    task automatic random_item();
        int                 prefix;
        int                 j;
        logic [FIELD_W-1:0] facts;
        prefix = sb.written_prefix();
        if ($urandom_range(0, 99) < 35) begin
            if (prefix < DEF_MAX_RULES && $urandom_range(0, 1) == 0) j = prefix;
            else j = $urandom_range(0, DEF_MAX_RULES - 1);
            write_rule(INDEX_W'(j), pick_tier(), pick_mask(), pick_mask(), rand64());
        end else begin
            if (prefix > 0 && $urandom_range(0, 1) == 0) begin
                j = $urandom_range(0, prefix - 1);
                facts = (rand64() | sb.required[j]) & ~sb.forbidden[j];
            end else begin
                case ($urandom_range(0, 3))
                    0: facts = rand64();
                    1: facts = rand64() | rand64();
                    2: facts = ALL_ONES;
                    default: facts = '0;
                endcase
            end
            evaluate(facts);
        end
    endtask

    task automatic random_phase(input logic [COUNT_W-1:0] count, input int items);
        set_walk_len(count);
        repeat (items) random_item();
    endtask

    initial begin
        int                 prefix;
        logic [COUNT_W-1:0] count;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_walk_len('0);
        evaluate('0);
        evaluate(ALL_ONES);
        write_rule(6'd0, 8'd1, '0, 64'h8000_0000_0000_0000, 64'h1);
        write_rule(6'd1, 8'd0, ALL_ONES, '0, 64'h2);
        write_rule(6'd2, 8'd3, 64'h1, '0, 64'h4);
        write_rule(6'd3, 8'd2, 64'h3, '0, 64'h8);
        write_rule(6'd4, 8'd255, '0, '0, ALL_ONES);
        write_rule(6'd63, 8'd255, ALL_ONES, ALL_ONES, ALL_ONES);
        set_walk_len(7'd5);
        evaluate('0);
        evaluate(ALL_ONES);
        evaluate(64'h3);
        evaluate(64'h8000_0000_0000_0003);
        evaluate(64'h8000_0000_0000_0000);
        write_rule(6'd0, 8'd2, '0, '0, 64'h10);
        evaluate(ALL_ONES);

        while (sent < 640) begin
            prefix = sb.written_prefix();
            case ($urandom_range(0, 5))
                0: count = '0;
                1: count = COUNT_W'(prefix);
                2: count = COUNT_W'($urandom_range(0, prefix));
                3: count = (prefix == DEF_MAX_RULES) ? 7'd127 : COUNT_W'(prefix);
                4: count = (prefix == DEF_MAX_RULES) ? COUNT_W'($urandom_range(65, 127))
                                                     : COUNT_W'($urandom_range(0, prefix));
                default: count = COUNT_W'($urandom_range(0, (prefix < 8) ? prefix : 8));
            endcase
            random_phase(count, $urandom_range(30, 80));
        end

        for (int i = 0; i < DEF_MAX_RULES; i++) begin
            if (!sb.written[i]) write_rule(INDEX_W'(i), pick_tier(), pick_mask(), pick_mask(),
                                           rand64());
        end
        random_phase(7'd64, 60);
        drain();
        quiet = 1'b1;
        random_phase(7'd127, 80);

        drain();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

[tiered_mask_rule_matcher.f]
design/tmrm_pkg.sv
design/tmrm_ram.sv
design/tiered_mask_rule_matcher.sv
bench/tb_top.sv
